// ----- src/dfq_pkg.sv -----
// ----------------------------------------------------------------------------
// dfq_pkg
// Shared types and constants of the deduplicating FIFO queue.
// ----------------------------------------------------------------------------
package dfq_pkg;

  // Default geometry
  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  // Fixed port widths
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Controls broadcast to every cell of the chain
  typedef struct packed {
    logic cmp;    // sample the duplicate compare
    logic shift;  // pop: take the neighbor's entry
    logic push;   // push: first free cell takes the value
  } cell_ctl_t;

endpackage

// ----- src/dfq_cell.sv -----
// ----------------------------------------------------------------------------
// dfq_cell
// One queue slot: holds an entry, compares it against an incoming value and
// hands its entry toward the front on a pop.
// ----------------------------------------------------------------------------
module dfq_cell #(
  parameter int WIDTH = dfq_pkg::WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dfq_pkg::cell_ctl_t ctl,
  input  logic [WIDTH-1:0]  cmp_value,
  input  logic [WIDTH-1:0]  push_value,
  input  logic              prev_valid,
  input  logic              next_valid,
  input  logic [WIDTH-1:0]  next_data,
  output logic              valid,
  output logic [WIDTH-1:0]  data,
  output logic              match
);

  logic             valid_r, valid_nxt;
  logic [WIDTH-1:0] data_r, data_nxt;
  logic             match_r, match_nxt;
  logic             load;

  // The first free cell behind the last held one takes a push
  assign load = ctl.push && !valid_r && prev_valid;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    match_nxt = match_r;
    if (ctl.shift) begin
      valid_nxt = next_valid;
      data_nxt  = next_data;
    end else if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = push_value;
    end
    if (ctl.cmp) begin
      match_nxt = valid_r && (data_r == cmp_value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;
  assign match = match_r;

endmodule

// ----- src/dedup_fifo_queue.sv -----
// ----------------------------------------------------------------------------
// dedup_fifo_queue
// FIFO queue that drops a push whose value is already held. Entries sit in a
// chain of cells with the oldest in cell 0; a pop shifts the chain one step.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+--------------------------------
//  in_     | input     | in_valid / in_stall  | mode, value
//  out_    | output    | out_valid / out_stall| status, front_value, back_value,
//          |           |                      | is_empty, entry_count
//
//  Steps: at the accept edge every cell registers its own compare against the
//  value; at the update step the match bits are reduced, the chain is updated
//  and the result is loaded into the output register. A new item is taken only
//  once the block is back in idle, so an item is not taken before the last one
//  is through.
//  Stalls: a held result blocks the update step only; the block waits with the
//  item latched until the output register frees up.
//  Reset: synchronous, clears all valid bits, counters and handshake state.
//
module dedup_fifo_queue #(
  parameter int DEPTH = dfq_pkg::DEPTH_DEF,
  parameter int WIDTH = dfq_pkg::WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [dfq_pkg::VAL_W-1:0]  in_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dfq_pkg::STAT_W-1:0] out_status,
  output logic [dfq_pkg::VAL_W-1:0]  out_front_value,
  output logic [dfq_pkg::VAL_W-1:0]  out_back_value,
  output logic                       out_is_empty,
  output logic [dfq_pkg::CNT_W-1:0]  out_entry_count
);

  localparam int CNT_BW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_CHECK = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // latched item
  logic             mode_r;
  logic [WIDTH-1:0] val_r;

  // chain
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_match;
  logic [WIDTH-1:0] cell_data [DEPTH];
  dfq_pkg::cell_ctl_t ctl;

  logic [CNT_BW-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0]  back_r;

  // output register
  logic                       out_valid_r;
  logic [dfq_pkg::STAT_W-1:0] out_status_r;
  logic [dfq_pkg::VAL_W-1:0]  out_front_r;
  logic [dfq_pkg::VAL_W-1:0]  out_back_r;
  logic                       out_empty_r;
  logic [dfq_pkg::CNT_W-1:0]  out_count_r;

  logic in_acc, out_free, apply;
  logic dup, full, empty;
  logic push_do, pop_do, empty_nxt;
  dfq_pkg::status_t status;
  logic [WIDTH-1:0] in_val_w, front_w, back_w;
  logic [63:0]      in_ext, front_ext, back_ext;
  logic [15:0]      cnt_ext;

  // Drop input bits above WIDTH, or zero-extend when WIDTH is wider
  assign in_ext   = 64'(in_value);
  assign in_val_w = in_ext[WIDTH-1:0];

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign apply    = (state_r == S_CHECK) && out_free;

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  assign ctl.cmp   = in_acc;
  assign ctl.shift = pop_do;
  assign ctl.push  = push_do;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             prev_v;
    logic             next_v;
    logic [WIDTH-1:0] next_d;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_d = '0;
    end else begin : g_inner
      assign next_v = cell_valid[i+1];
      assign next_d = cell_data[i+1];
    end

    dfq_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cmp_value (in_val_w),
      .push_value(val_r),
      .prev_valid(prev_v),
      .next_valid(next_v),
      .next_data (next_d),
      .valid     (cell_valid[i]),
      .data      (cell_data[i]),
      .match     (cell_match[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Decide the step
  // ---------------------------------------------------------------------------
  assign dup   = |cell_match;
  assign full  = cell_valid[DEPTH-1];
  assign empty = !cell_valid[0];

  always_comb begin
    push_do = 1'b0;
    pop_do  = 1'b0;
    status  = dfq_pkg::ST_DONE;
    if (!mode_r) begin
      // duplicate wins over full
      if (dup) begin
        status = dfq_pkg::ST_DUP;
      end else if (full) begin
        status = dfq_pkg::ST_FULL;
      end else begin
        push_do = apply;
      end
    end else begin
      if (empty) begin
        status = dfq_pkg::ST_EMPTY;
      end else begin
        pop_do = apply;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_do) begin
      cnt_nxt = cnt_r + CNT_BW'(1);
    end else if (pop_do) begin
      cnt_nxt = cnt_r - CNT_BW'(1);
    end
  end

  // Front, back and empty as they stand after the step
  always_comb begin
    empty_nxt = empty;
    front_w   = cell_data[0];
    back_w    = back_r;
    if (push_do) begin
      empty_nxt = 1'b0;
      back_w    = val_r;
      if (empty) begin
        front_w = val_r;
      end
    end else if (pop_do) begin
      empty_nxt = !cell_valid[1];
      front_w   = cell_data[1];
    end
    if (empty_nxt) begin
      front_w = '0;
      back_w  = '0;
    end
  end

  assign front_ext = 64'(front_w);
  assign back_ext  = 64'(back_w);
  assign cnt_ext   = 16'(cnt_nxt);

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (apply) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: latch the item, track the newest entry, load the result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
      val_r  <= in_val_w;
    end
    if (push_do) begin
      back_r <= val_r;
    end
    if (apply) begin
      out_status_r <= status;
      out_front_r  <= front_ext[dfq_pkg::VAL_W-1:0];
      out_back_r   <= back_ext[dfq_pkg::VAL_W-1:0];
      out_empty_r  <= empty_nxt;
      out_count_r  <= cnt_ext[dfq_pkg::CNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_is_empty    = out_empty_r;
  assign out_entry_count = out_count_r;

`ifndef ASSERT_OFF
  // Held entries always form an unbroken run from the front cell
  a_thermo : assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("cell valid bits not contiguous from the front");

  // Count agrees with the number of held cells
  a_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(cnt_r))
    else $error("entry count out of step with the chain");

  // An accepted item is checked in the next cycle
  a_check : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_CHECK))
    else $error("accepted item not taken to the check step");

  // A new result comes only from the check step
  a_result : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_CHECK))
    else $error("result raised outside the check step");

  // Entry count changes only on an update step and never on stall
  a_onechg : assert property (@(posedge clk) disable iff (!rst_n)
    !apply |=> (cnt_r == $past(cnt_r)))
    else $error("entry count changed without an update step");
`endif

endmodule
